@@ rtl/dtq_pkg.sv @@
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and constants for the deadline-ordered timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int TIME_BITS   = 48;
    localparam int ID_BITS     = 32;
    localparam int MAX_RESULTS = 64;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    // opcodes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_EXPIRE = 2'd2;

    // result status codes
    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_CANCELLED = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_FIRED     = 3'd4;
    localparam logic [2:0] ST_NONE_DUE  = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_SCAN,
        S_SHIFT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [TIME_BITS-1:0] deadline;
        logic [ID_BITS-1:0]   id;
    } t_entry;

    typedef struct packed {
        logic [2:0]           status;
        logic [ID_BITS-1:0]   timer_id;
        logic [TIME_BITS-1:0] earliest_deadline;
        logic                 queue_empty;
        logic                 last;
    } t_result;

endpackage

@@ rtl/dtq_ram.sv @@
// ----------------------------------------------------------------------------
// dtq_ram
// Timer entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dtq_ram (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [dtq_pkg::IDX_W-1:0] i_waddr,
    input  dtq_pkg::t_entry          i_wdata,
    input  logic [dtq_pkg::IDX_W-1:0] i_raddr,
    output dtq_pkg::t_entry          o_rdata
);
    import dtq_pkg::*;

    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/dtq_seq.sv @@
// ----------------------------------------------------------------------------
// dtq_seq
// Sequencer: scans, compacts and appends entries in the store, tracks the
// earliest entry and produces result beats.
// ----------------------------------------------------------------------------
module dtq_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_opcode,
    input  logic [dtq_pkg::TIME_BITS-1:0] i_now,
    input  logic signed [dtq_pkg::TIME_BITS-1:0] i_delay,
    input  logic [dtq_pkg::ID_BITS-1:0]   i_cancel_id,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output dtq_pkg::t_result              o_res
);
    import dtq_pkg::*;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [ID_BITS-1:0]   r_next_id, n_next_id;
    logic [1:0]           r_op, n_op;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic [ID_BITS-1:0]   r_cid, n_cid;
    logic [NRES_W-1:0]    r_nres, n_nres;
    logic [CNT_W-1:0]     r_addr, n_addr;
    logic                 r_rd_pend, n_rd_pend;
    logic [IDX_W-1:0]     r_rd_idx, n_rd_idx;
    logic                 r_best_vld, n_best_vld;
    t_entry               r_best, n_best;
    logic [IDX_W-1:0]     r_best_slot, n_best_slot;
    t_entry               r_min, n_min;
    logic [IDX_W-1:0]     r_min_slot, n_min_slot;
    logic [2:0]           r_status, n_status;
    logic [ID_BITS-1:0]   r_tid, n_tid;
    logic                 r_last, n_last;

    logic                 we;
    logic [IDX_W-1:0]     waddr;
    t_entry               wdata;
    t_entry               rdata;
    logic                 issue;
    logic                 better;
    logic [TIME_BITS-1:0] dly;
    logic [TIME_BITS:0]   sum;
    logic [TIME_BITS-1:0] dl;

    dtq_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_addr[IDX_W-1:0]),
        .o_rdata (rdata)
    );

    // deadline for add, clamped and saturated
    always_comb begin
        dly = i_delay[TIME_BITS-1] ? '0 : i_delay;
        sum = {1'b0, i_now} + {1'b0, dly};
        dl  = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
    end

    // returned entry beats the running best
    assign better = !r_best_vld || (rdata.deadline < r_best.deadline) ||
                    (rdata.deadline == r_best.deadline && rdata.id < r_best.id);

    assign issue   = (r_addr < r_count);
    assign o_stall = (r_state != S_IDLE);

    // result beat
    always_comb begin
        o_res_valid              = (r_state == S_EMIT);
        o_res.status             = r_status;
        o_res.timer_id           = r_tid;
        o_res.earliest_deadline  = (r_count != '0) ? r_min.deadline : '0;
        o_res.queue_empty        = (r_count == '0);
        o_res.last               = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_next_id <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_next_id <= n_next_id;
            r_rd_pend <= n_rd_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_now       <= n_now;
        r_cid       <= n_cid;
        r_nres      <= n_nres;
        r_addr      <= n_addr;
        r_rd_idx    <= n_rd_idx;
        r_best_vld  <= n_best_vld;
        r_best      <= n_best;
        r_best_slot <= n_best_slot;
        r_min       <= n_min;
        r_min_slot  <= n_min_slot;
        r_status    <= n_status;
        r_tid       <= n_tid;
        r_last      <= n_last;
    end

    // next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_next_id   = r_next_id;
        n_op        = r_op;
        n_now       = r_now;
        n_cid       = r_cid;
        n_nres      = r_nres;
        n_addr      = r_addr;
        n_rd_pend   = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_best_vld  = r_best_vld;
        n_best      = r_best;
        n_best_slot = r_best_slot;
        n_min       = r_min;
        n_min_slot  = r_min_slot;
        n_status    = r_status;
        n_tid       = r_tid;
        n_last      = r_last;
        we          = 1'b0;
        waddr       = r_count[IDX_W-1:0];
        wdata.deadline = dl;
        wdata.id       = r_next_id;

        unique case (r_state)
            S_IDLE: begin
                n_addr     = '0;
                n_best_vld = 1'b0;
                if (i_valid) begin
                    n_op   = i_opcode;
                    n_now  = i_now;
                    n_cid  = i_cancel_id;
                    n_nres = '0;
                    if (i_opcode == OP_ADD) begin
                        n_last = 1'b1;
                        if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                            n_status = ST_FULL;
                            n_tid    = '0;
                            n_state  = S_EMIT;
                        end else begin
                            we        = 1'b1;
                            n_count   = r_count + 1'b1;
                            n_status  = ST_ADDED;
                            n_tid     = r_next_id;
                            n_next_id = r_next_id + 1'b1;
                            n_state   = S_SCAN;
                        end
                    end else if (i_opcode == OP_CANCEL) begin
                        n_state = S_FIND;
                    end else if (i_opcode == OP_EXPIRE) begin
                        if (r_count != '0 && r_min.deadline <= i_now) begin
                            n_status = ST_FIRED;
                            n_tid    = r_min.id;
                            n_addr   = CNT_W'(r_min_slot) + 1'b1;
                            n_state  = S_SHIFT;
                        end else begin
                            n_status = ST_NONE_DUE;
                            n_tid    = '0;
                            n_last   = 1'b1;
                            n_state  = S_EMIT;
                        end
                    end
                end
            end

            // look for the oldest entry with the cancel id
            S_FIND: begin
                if (issue) begin
                    n_addr    = r_addr + 1'b1;
                    n_rd_pend = 1'b1;
                    n_rd_idx  = r_addr[IDX_W-1:0];
                end
                if (r_rd_pend && rdata.id == r_cid) begin
                    n_status  = ST_CANCELLED;
                    n_tid     = r_cid;
                    n_addr    = CNT_W'(r_rd_idx) + 1'b1;
                    n_rd_pend = 1'b0;
                    n_state   = S_SHIFT;
                end else if (!issue && !r_rd_pend) begin
                    n_status = ST_NOT_FOUND;
                    n_tid    = r_cid;
                    n_last   = 1'b1;
                    n_state  = S_EMIT;
                end
            end

            // close the gap: move each later entry down one slot
            S_SHIFT: begin
                if (issue) begin
                    n_addr    = r_addr + 1'b1;
                    n_rd_pend = 1'b1;
                    n_rd_idx  = r_addr[IDX_W-1:0];
                end
                if (r_rd_pend) begin
                    we    = 1'b1;
                    waddr = r_rd_idx - 1'b1;
                    wdata = rdata;
                end
                if (!issue && !r_rd_pend) begin
                    n_count    = r_count - 1'b1;
                    n_addr     = '0;
                    n_best_vld = 1'b0;
                    n_state    = S_SCAN;
                end
            end

            // find the earliest entry, ties broken by lower id
            S_SCAN: begin
                if (issue) begin
                    n_addr    = r_addr + 1'b1;
                    n_rd_pend = 1'b1;
                    n_rd_idx  = r_addr[IDX_W-1:0];
                end
                if (r_rd_pend && better) begin
                    n_best_vld  = 1'b1;
                    n_best      = rdata;
                    n_best_slot = r_rd_idx;
                end
                if (!issue && !r_rd_pend) begin
                    n_min      = r_best;
                    n_min_slot = r_best_slot;
                    n_state    = S_EMIT;
                    if (r_op == OP_EXPIRE) begin
                        n_last = !((r_nres + 1'b1) < NRES_W'(MAX_RESULTS) &&
                                   r_count != '0 && r_best.deadline <= r_now);
                    end else begin
                        n_last = 1'b1;
                    end
                end
            end

            S_EMIT: begin
                if (i_res_ready) begin
                    n_nres = r_nres + 1'b1;
                    if (!r_last && r_op == OP_EXPIRE) begin
                        n_status = ST_FIRED;
                        n_tid    = r_min.id;
                        n_addr   = CNT_W'(r_min_slot) + 1'b1;
                        n_state  = S_SHIFT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ rtl/deadline_timer_queue.sv @@
// ----------------------------------------------------------------------------
// deadline_timer_queue
// Timer queue ordered by deadline, with add, cancel and expire commands.
// ----------------------------------------------------------------------------
// Input channel: i_valid/o_stall with opcode, now, delay and cancel_id. An
// input beat is taken only while the queue is idle; o_stall is high while a
// command is being worked.
// Output channel: o_valid/i_stall. Each command gives one result beat, or
// for expire one beat per fired timer (up to 64), the final one with o_last.
// An unknown opcode gives no beat.
// Operation: an add appends the entry, then scans the entry store for the
// earliest deadline. A cancel does a search, a compaction of later slots
// and a rescan. Each fired timer costs a compaction and a rescan. The
// entry store has a single read port and is read one entry per cycle.
// Results pass through an output register; a stalled beat holds and the
// queue waits for it to drain. Reset empties the queue and zeroes the id
// counter; the entry store itself is not cleared.
// ----------------------------------------------------------------------------
module deadline_timer_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_opcode,
    input  logic [dtq_pkg::TIME_BITS-1:0] i_now,
    input  logic signed [dtq_pkg::TIME_BITS-1:0] i_delay,
    input  logic [dtq_pkg::ID_BITS-1:0]   i_cancel_id,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [2:0]                    o_status,
    output logic [dtq_pkg::ID_BITS-1:0]   o_timer_id,
    output logic [dtq_pkg::TIME_BITS-1:0] o_earliest_deadline,
    output logic                          o_queue_empty,
    output logic                          o_last
);
    import dtq_pkg::*;

    logic    res_valid;
    logic    res_ready;
    t_result res;
    logic    r_ov;
    t_result r_out;

    dtq_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_opcode    (i_opcode),
        .i_now       (i_now),
        .i_delay     (i_delay),
        .i_cancel_id (i_cancel_id),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // output register loads when empty or when its beat is taken
    assign res_ready = !r_ov || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (res_ready) begin
            r_ov <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid             = r_ov;
    assign o_status            = r_out.status;
    assign o_timer_id          = r_out.timer_id;
    assign o_earliest_deadline = r_out.earliest_deadline;
    assign o_queue_empty       = r_out.queue_empty;
    assign o_last              = r_out.last;

endmodule

@@ sim/deadline_timer_queue_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_timer_queue_test
// Self-checking bench for the timer queue: a behavioral queue model predicts
// every result beat of add, cancel and expire commands, and a monitor
// compares each beat seen on the output channel with the oldest prediction.
// ----------------------------------------------------------------------------
module deadline_timer_queue_test;
    import dtq_pkg::*;

    localparam logic [1:0] OP_UNKNOWN = 2'd3;
    localparam int LIMIT_CYCLES = 2000000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [1:0]           i_opcode;
    logic [TIME_BITS-1:0] i_now;
    logic signed [TIME_BITS-1:0] i_delay;
    logic [ID_BITS-1:0]   i_cancel_id;
    logic                 o_valid;
    logic                 i_stall;
    logic [2:0]           o_status;
    logic [ID_BITS-1:0]   o_timer_id;
    logic [TIME_BITS-1:0] o_earliest_deadline;
    logic                 o_queue_empty;
    logic                 o_last;

    deadline_timer_queue u_dut (.*);

    // queue model state
    logic [TIME_BITS-1:0] q_deadline[$];
    logic [ID_BITS-1:0]   q_id[$];
    logic [ID_BITS-1:0]   id_counter;
    t_result              pending_results[$];

    int  mismatches;
    int  cycles;
    logic [TIME_BITS-1:0] clock_now;   // running time base for stimulus

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("deadline_timer_queue: mismatch");
            $finish;
        end
    end

    // receiver stall pattern: phases of no stall, random, and heavy stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            case ((cycles / 300) % 3)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                default: i_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    function automatic int earliest_slot();
        int best;
        best = 0;
        for (int i = 1; i < q_deadline.size(); i++)
            if (q_deadline[i] < q_deadline[best] ||
                (q_deadline[i] == q_deadline[best] && q_id[i] < q_id[best]))
                best = i;
        return best;
    endfunction

    function automatic void push_result(logic [2:0] st, logic [ID_BITS-1:0] id);
        t_result r;
        r.status = st;
        r.timer_id = id;
        r.queue_empty = (q_deadline.size() == 0);
        r.earliest_deadline = r.queue_empty ? '0 : q_deadline[earliest_slot()];
        r.last = 1'b0;
        pending_results.insert(pending_results.size(), r);
    endfunction

    // predict the result beats of one accepted command
    function automatic void predict_queue(logic [1:0] op, logic [TIME_BITS-1:0] now,
                                          logic signed [TIME_BITS-1:0] dly,
                                          logic [ID_BITS-1:0] cid);
        logic [TIME_BITS-1:0] d;
        logic [TIME_BITS-1:0] dl;
        int   n;
        int   k;
        bit   found;
        t_result r;
        n = 0;
        if (op == OP_ADD) begin
            if (q_deadline.size() >= QUEUE_DEPTH) begin
                push_result(ST_FULL, '0);
            end else begin
                d = dly[TIME_BITS-1] ? '0 : dly;
                dl = (d > TIME_MAX - now) ? TIME_MAX : now + d;
                q_deadline.insert(q_deadline.size(), dl);
                q_id.insert(q_id.size(), id_counter);
                push_result(ST_ADDED, id_counter);
                id_counter++;
            end
            n = 1;
        end else if (op == OP_CANCEL) begin
            found = 0;
            for (int i = 0; i < q_id.size(); i++) begin
                if (q_id[i] == cid) begin
                    q_id.delete(i);
                    q_deadline.delete(i);
                    found = 1;
                    break;
                end
            end
            push_result(found ? ST_CANCELLED : ST_NOT_FOUND, cid);
            n = 1;
        end else if (op == OP_EXPIRE) begin
            while (n < MAX_RESULTS && q_deadline.size() > 0) begin
                k = earliest_slot();
                if (q_deadline[k] > now) break;
                r.timer_id = q_id[k];
                q_id.delete(k);
                q_deadline.delete(k);
                push_result(ST_FIRED, r.timer_id);
                n++;
            end
            if (n == 0) begin
                push_result(ST_NONE_DUE, '0);
                n = 1;
            end
        end
        // mark the final beat of this command
        if (op != OP_UNKNOWN) begin
            k = pending_results.size() - 1;
            r = pending_results[k];
            r.last = 1'b1;
            pending_results[k] = r;
        end
    endfunction

    // result monitor
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: status %0d id %0h", o_status, o_timer_id);
            end else begin
                exp_r = pending_results.pop_front();
                if (o_status !== exp_r.status || o_timer_id !== exp_r.timer_id ||
                    o_earliest_deadline !== exp_r.earliest_deadline ||
                    o_queue_empty !== exp_r.queue_empty || o_last !== exp_r.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat differs: exp %0d %0h %0h %0b %0b got %0d %0h %0h %0b %0b",
                                 exp_r.status, exp_r.timer_id, exp_r.earliest_deadline,
                                 exp_r.queue_empty, exp_r.last, o_status, o_timer_id,
                                 o_earliest_deadline, o_queue_empty, o_last);
                end
            end
        end
    end

    // send one command beat, optionally followed by a random gap
    task automatic send_cmd(logic [1:0] op, logic [TIME_BITS-1:0] now,
                            logic signed [TIME_BITS-1:0] dly, logic [ID_BITS-1:0] cid);
        i_valid     <= 1'b1;
        i_opcode    <= op;
        i_now       <= now;
        i_delay     <= dly;
        i_cancel_id <= cid;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_queue(op, now, dly, cid);
        if ($urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    // field extremes, saturation, negative delay, unknown opcode
    task automatic test_extremes();
        send_cmd(OP_EXPIRE, '0, '0, '0);
        send_cmd(OP_CANCEL, '0, '0, 32'hFFFF_FFFF);
        send_cmd(OP_ADD, '0, '0, '0);
        send_cmd(OP_ADD, TIME_MAX, {1'b0, {(TIME_BITS-1){1'b1}}}, 32'hFFFF_FFFF);
        send_cmd(OP_ADD, 48'h7FFF_FFFF_FFFF, {1'b0, {(TIME_BITS-1){1'b1}}}, '0);
        send_cmd(OP_ADD, 48'h1000, {1'b1, {(TIME_BITS-1){1'b0}}}, '0);
        send_cmd(OP_ADD, 48'h1000, -48'sd1, '0);
        send_cmd(OP_UNKNOWN, TIME_MAX, -48'sd1, 32'hFFFF_FFFF);
        send_cmd(OP_CANCEL, '0, '0, 32'd1);
        send_cmd(OP_CANCEL, '0, '0, 32'd1);
        send_cmd(OP_EXPIRE, 48'h1000, '0, '0);
        send_cmd(OP_EXPIRE, TIME_MAX, '0, '0);
        drain();
    endtask

    // fill to full, overflow, then expires that fire the due timers and the rest
    task automatic test_full_queue();
        for (int i = 0; i < QUEUE_DEPTH + 2; i++)
            send_cmd(OP_ADD, 48'd100, TIME_BITS'($urandom_range(0, 3)), '0);
        send_cmd(OP_EXPIRE, 48'd102, '0, '0);
        send_cmd(OP_EXPIRE, 48'd200, '0, '0);
        drain();
    endtask

    // random mix of traffic, unknown opcodes included, around a moving time base
    task automatic test_random_mix(int count);
        logic [1:0] op;
        logic signed [TIME_BITS-1:0] dly;
        logic [ID_BITS-1:0] cid;
        int sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            clock_now += TIME_BITS'($urandom_range(0, 40));
            if (sel < 45)      op = OP_ADD;
            else if (sel < 65) op = OP_CANCEL;
            else if (sel < 95) op = OP_EXPIRE;
            else               op = OP_UNKNOWN;
            case ($urandom_range(0, 9))
                0: dly = TIME_BITS'({$urandom, $urandom});
                1: dly = -$signed({16'd0, $urandom});
                default: dly = TIME_BITS'($urandom_range(0, 200));
            endcase
            cid = ($urandom_range(0, 3) == 0 || q_id.size() == 0) ? $urandom
                  : q_id[$urandom_range(0, q_id.size() - 1)] + $urandom_range(0, 1);
            send_cmd(op, ($urandom_range(0, 19) == 0) ? TIME_BITS'({$urandom, $urandom})
                                                      : clock_now,
                     dly, cid);
            if ($urandom_range(0, 15) == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(5, 30)) @(posedge i_clk);
            end
        end
        send_cmd(OP_EXPIRE, TIME_MAX, '0, '0);
        send_cmd(OP_EXPIRE, TIME_MAX, '0, '0);
        drain();
    endtask

    // id counter wrap is reached only through many adds; exercise high id bits
    // via cancel of random wide ids instead
    task automatic test_wide_ids();
        for (int i = 0; i < 8; i++)
            send_cmd(OP_CANCEL, '0, '0, $urandom);
        drain();
    endtask

    initial begin
        clock_now  = 48'd5000;
        id_counter = '0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_opcode    = OP_ADD;
        i_now       = '0;
        i_delay     = '0;
        i_cancel_id = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_full_queue();
        test_wide_ids();
        test_random_mix(90);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("deadline_timer_queue: match");
        end else begin
            $display("deadline_timer_queue: mismatch");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/dtq_pkg.sv
rtl/dtq_ram.sv
rtl/dtq_seq.sv
rtl/deadline_timer_queue.sv
sim/deadline_timer_queue_test.sv
